>>> hw/rtl/gpk_pkg.sv
// ----------------------------------------------------------------------------
// gpk_pkg
// shared types, codes and key tables for the game port protection key
// ----------------------------------------------------------------------------
package gpk_pkg;

    localparam logic [6:0] LFSR_SEED = 7'h6B;

    // key model codes
    localparam logic [2:0] KEY_NONE    = 3'd0;
    localparam logic [2:0] KEY_NAND    = 3'd1;
    localparam logic [2:0] KEY_SHIFT   = 3'd2;
    localparam logic [2:0] KEY_IM500   = 3'd3;
    localparam logic [2:0] KEY_IM1000  = 3'd4;
    localparam logic [2:0] KEY_IM1500  = 3'd5;
    localparam logic [2:0] KEY_COMPILE = 3'd6;

    // command codes
    localparam logic [1:0] CMD_SWITCH  = 2'd0;
    localparam logic [1:0] CMD_BUTTON1 = 2'd1;
    localparam logic [1:0] CMD_BUTTON2 = 2'd2;
    localparam logic [1:0] CMD_PADDLE  = 2'd3;

    localparam logic [1:0] KEY_PADDLE  = 2'd3;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] switch_address;
        logic [1:0] paddle_number;
    } t_in;

    typedef struct packed {
        logic       driven;
        logic [7:0] read_value;
    } t_out;

    typedef struct packed {
        logic [3:0] ann;
        logic [6:0] lfsr;
    } t_key_state;

    function automatic logic [7:0] cmp_tab(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'hFF;
            2'd1:    v = 8'h96;
            2'd2:    v = 8'h96;
            default: v = 8'h50;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] m500_lo(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h3F;
            3'd1:    v = 8'h2E;
            3'd2:    v = 8'h54;
            3'd3:    v = 8'h54;
            3'd4:    v = 8'h2E;
            3'd5:    v = 8'h22;
            3'd6:    v = 8'h72;
            default: v = 8'h17;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] m500_hi(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h6F;
            3'd1:    v = 8'h54;
            3'd2:    v = 8'h94;
            3'd3:    v = 8'h94;
            3'd4:    v = 8'h54;
            3'd5:    v = 8'h40;
            3'd6:    v = 8'hC4;
            default: v = 8'h2E;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] m1000_tab(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'd34;
            3'd1:    v = 8'd151;
            3'd2:    v = 8'd48;
            3'd3:    v = 8'd64;
            3'd4:    v = 8'd113;
            3'd5:    v = 8'd113;
            3'd6:    v = 8'd64;
            default: v = 8'd85;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] m1500_tab(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'd153;
            3'd1:    v = 8'd34;
            3'd2:    v = 8'd64;
            3'd3:    v = 8'd34;
            3'd4:    v = 8'd48;
            3'd5:    v = 8'd86;
            3'd6:    v = 8'd114;
            default: v = 8'd48;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/game_port_protection_key_core.sv
// ----------------------------------------------------------------------------
// game_port_protection_key_core
// protection key on the game port: annunciator tracking, lfsr and read answers
// ----------------------------------------------------------------------------
// result: the result word is registered and valid in the cycle after the input word is accepted
// throughput: one word per cycle while the output is not stalled, set by the single output register
// a stalled output holds the next input only while the output is full
// reset: synchronous active low; model none, annunciators zero, lfsr 0x6B
// ----------------------------------------------------------------------------
module game_port_protection_key_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic    [2:0] i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  gpk_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output gpk_pkg::t_out o_out
);

    logic [2:0]          r_model;
    gpk_pkg::t_key_state r_state;
    gpk_pkg::t_key_state n_state;
    gpk_pkg::t_out       n_out;
    gpk_pkg::t_out       r_out;
    logic                r_out_valid;
    logic                in_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    gpk_eval u_eval (
        .i_model (r_model),
        .i_state (r_state),
        .i_in    (i_in),
        .o_state (n_state),
        .o_out   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model      <= gpk_pkg::KEY_NONE;
            r_state.ann  <= 4'd0;
            r_state.lfsr <= gpk_pkg::LFSR_SEED;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_model <= i_cfg_data;
            end
            if (in_accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    a_not_driven_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.driven || r_out.read_value == 8'd0))
        else $error("undriven read returned nonzero value");

    a_lfsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.lfsr != 7'd0)
        else $error("lfsr reached all zero");

    a_read_keeps_ann: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in.command != gpk_pkg::CMD_SWITCH) |=> $stable(r_state.ann))
        else $error("read access changed annunciators");

    a_lfsr_model: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_model != gpk_pkg::KEY_SHIFT) |=> $stable(r_state.lfsr))
        else $error("lfsr moved without shift-register key");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted word produced no result");

endmodule

>>> hw/rtl/gpk_eval.sv
// ----------------------------------------------------------------------------
// gpk_eval
// next key state and read answer for one game port access
// ----------------------------------------------------------------------------
module gpk_eval (
    input  logic                [2:0] i_model,
    input  gpk_pkg::t_key_state       i_state,
    input  gpk_pkg::t_in              i_in,
    output gpk_pkg::t_key_state       o_state,
    output gpk_pkg::t_out             o_out
);

    logic [1:0] an_sel;
    logic       level;
    logic [3:0] ann_new;
    logic       fb;
    logic [8:0] m500_sum;
    logic [7:0] m500_val;
    logic [2:0] mode;

    assign an_sel   = i_in.switch_address[2:1];
    assign level    = i_in.switch_address[0];
    assign fb       = i_state.lfsr[1] ^ i_state.lfsr[0];
    assign mode     = i_state.ann[2:0];
    assign m500_sum = {1'b0, gpk_pkg::m500_lo(mode)} + {1'b0, gpk_pkg::m500_hi(mode)}
                      - 9'd1;
    assign m500_val = m500_sum[8:1];

    always_comb begin
        ann_new         = i_state.ann;
        ann_new[an_sel] = level;
    end

    // state update, only annunciator accesses at addresses 8..15 change it
    always_comb begin
        o_state = i_state;
        if (i_in.command == gpk_pkg::CMD_SWITCH && i_in.switch_address[3]) begin
            o_state.ann = ann_new;
            if (i_model == gpk_pkg::KEY_SHIFT) begin
                if ((an_sel == 2'd3 && level) || i_state.ann[3]) begin
                    o_state.lfsr = gpk_pkg::LFSR_SEED;
                end else if (an_sel == 2'd2 && !level && i_state.ann[2]) begin
                    // falling edge on an2 clocks the lfsr
                    o_state.lfsr = {fb, i_state.lfsr[6:1]};
                end
            end
        end
    end

    always_comb begin
        o_out = '0;
        case (i_in.command)
            gpk_pkg::CMD_BUTTON1: begin
                if (i_model == gpk_pkg::KEY_COMPILE) begin
                    o_out.driven = 1'b1;
                end
            end
            gpk_pkg::CMD_BUTTON2: begin
                if (i_model == gpk_pkg::KEY_NAND) begin
                    o_out.driven     = 1'b1;
                    o_out.read_value = {7'd0, ~(i_state.ann[0] & i_state.ann[1]
                                                & i_state.ann[2])};
                end else if (i_model == gpk_pkg::KEY_SHIFT) begin
                    o_out.driven     = 1'b1;
                    o_out.read_value = {7'd0, i_state.lfsr[0]};
                end
            end
            gpk_pkg::CMD_PADDLE: begin
                if (i_in.paddle_number == gpk_pkg::KEY_PADDLE) begin
                    if (i_model == gpk_pkg::KEY_COMPILE) begin
                        o_out.driven     = 1'b1;
                        o_out.read_value = gpk_pkg::cmp_tab({i_state.ann[2], i_state.ann[0]});
                    end else if (!i_state.ann[3]) begin
                        // interface modules are unpowered while an3 is set
                        case (i_model)
                            gpk_pkg::KEY_IM500: begin
                                o_out.driven     = 1'b1;
                                o_out.read_value = m500_val;
                            end
                            gpk_pkg::KEY_IM1000: begin
                                o_out.driven     = 1'b1;
                                o_out.read_value = gpk_pkg::m1000_tab(mode);
                            end
                            gpk_pkg::KEY_IM1500: begin
                                o_out.driven     = 1'b1;
                                o_out.read_value = gpk_pkg::m1500_tab(mode);
                            end
                            default: begin
                                o_out = '0;
                            end
                        endcase
                    end
                end
            end
            default: begin
                o_out = '0;
            end
        endcase
    end

endmodule
